/* sv/bia_pkg.sv */
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, types and helpers for the bitmap id allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int MAP_WORDS = 8;
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int ID_W      = 8;
  localparam int HINT_W    = ID_W + 1;

  typedef logic [31:0]     map_word_t;
  typedef logic [ID_W-1:0] id_t;
  typedef logic [1:0]      func_t;

  localparam func_t FUNC_ALLOC = 2'd0;
  localparam func_t FUNC_FREE  = 2'd1;
  localparam func_t FUNC_CHECK = 2'd2;
  localparam func_t FUNC_INIT  = 2'd3;

  localparam logic CFG_MAX_ID   = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  localparam id_t        MAX_ID_RST   = 8'd255;
  localparam logic [4:0] RESERVED_RST = 5'd1;

  // lowest set bit, 31 when none is set
  function automatic logic [4:0] lowest_set(input map_word_t v);
    logic [4:0] k;
    k = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

  function automatic logic in_map(input logic [HINT_W-1:0] n);
    return (32'(n[HINT_W-1:5]) < 32'(MAP_WORDS));
  endfunction

endpackage

/* sv/bitmap_id_allocator_top.sv */
// ----------------------------------------------------------------------------
// bitmap_id_allocator_top
// Next-fit id allocator over a free bitmap, with free, check and init ops.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  in_*     in   tuser[1:0] func, tdata[7:0] id
//  out_*    out  tdata[7:0] id_out, tdata[8] in_use
//  cfg_*    in   index 0 max_id, index 1 reserved_count, data[7:0]
//
//  Free, check and init go from EXEC to DONE, then into the output register.
//  Alloc goes EXEC, HINT, then WB when the hint id is free, DONE when the hint
//  fails outright, else SCAN over k map words (1..MAP_WORDS), one word per
//  cycle through a single word reader and lowest-bit encoder, then WB or DONE.
//  in_tready is low while a transaction is in work and rises with the result,
//  so no new item is taken until the last result is in the output register.
//  A finished result waits in DONE while the output register is still full.
//  Synchronous active-low reset; the map resets with reserved_count = 1.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_top
  import bia_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] id
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] id_out, [8] in_use
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_HINT = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]              state_r, state_nxt;
  map_word_t               map_r [MAP_WORDS];
  map_word_t               map_nxt [MAP_WORDS];
  id_t                     last_id_r, last_id_nxt;
  id_t                     max_id_r;
  logic [4:0]              reserved_r;
  func_t                   func_r;
  id_t                     id_r;
  logic [HINT_W-1:0]       hint_r, hint_nxt;
  logic [WIDX_W-1:0]       scan_r, scan_nxt;
  id_t                     gid_r, gid_nxt;
  id_t                     res_id_r, res_id_nxt;
  logic                    res_use_r, res_use_nxt;
  logic                    out_valid_r;
  id_t                     out_id_r;
  logic                    out_use_r;

  // shared word reader and bit encoder
  logic [WIDX_W-1:0]       rd_idx;
  map_word_t               rd_word;
  logic [4:0]              rd_bit;
  logic [HINT_W-1:0]       hint_add;
  logic [HINT_W-1:0]       id_ext;
  logic [HINT_W-1:0]       max_ext;
  logic [HINT_W-1:0]       scan_gid;
  logic                    id_above;
  logic                    hint_above;
  logic                    load_out;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_use_r, out_id_r};

  assign max_ext    = {1'b0, max_id_r};
  assign id_ext     = {1'b0, id_r};
  assign hint_add   = {1'b0, last_id_r} + 9'd1;
  assign id_above   = id_ext > max_ext;
  assign hint_above = hint_r > max_ext;
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    unique case (state_r)
      ST_HINT: rd_idx = hint_r[WIDX_W+4:5];
      ST_SCAN: rd_idx = scan_r;
      ST_WB:   rd_idx = gid_r[WIDX_W+4:5];
      default: rd_idx = id_r[WIDX_W+4:5];
    endcase
  end

  assign rd_word  = map_r[rd_idx];
  assign rd_bit   = lowest_set(rd_word);
  assign scan_gid = HINT_W'({scan_r, rd_bit});

  always_comb begin
    state_nxt   = state_r;
    map_nxt     = map_r;
    last_id_nxt = last_id_r;
    hint_nxt    = hint_r;
    scan_nxt    = scan_r;
    gid_nxt     = gid_r;
    res_id_nxt  = res_id_r;
    res_use_nxt = res_use_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_id_nxt  = '0;
        res_use_nxt = 1'b0;
        state_nxt   = ST_DONE;
        unique case (func_r)
          FUNC_ALLOC: begin
            hint_nxt  = (hint_add >= max_ext) ? hint_add - max_ext : hint_add;
            state_nxt = ST_HINT;
          end
          FUNC_FREE: begin
            if (id_r != '0 && !id_above && in_map(id_ext)) begin
              map_nxt[rd_idx][id_r[4:0]] = 1'b1;
            end
          end
          FUNC_CHECK: begin
            res_use_nxt = !id_above && (!in_map(id_ext) || !rd_word[id_r[4:0]]);
          end
          default: begin
            for (int w = 0; w < MAP_WORDS; w++) begin
              map_nxt[w] = '1;
            end
            map_nxt[0] = '1 << reserved_r;
          end
        endcase
      end
      ST_HINT: begin
        if (hint_above || (in_map(hint_r) && rd_word[hint_r[4:0]])) begin
          last_id_nxt = hint_r[ID_W-1:0];
          if (hint_r == '0 || hint_above) begin
            state_nxt = ST_DONE;
          end else begin
            gid_nxt   = hint_r[ID_W-1:0];
            state_nxt = ST_WB;
          end
        end else begin
          scan_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_word != '0) begin
          if (scan_gid == '0 || scan_gid > max_ext) begin
            state_nxt = ST_DONE;
          end else begin
            gid_nxt   = scan_gid[ID_W-1:0];
            state_nxt = ST_WB;
          end
        end else if (32'(scan_r) == MAP_WORDS - 1) begin
          state_nxt = ST_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_WB: begin
        map_nxt[rd_idx][gid_r[4:0]] = 1'b0;
        last_id_nxt = gid_r;
        res_id_nxt  = gid_r;
        state_nxt   = ST_DONE;
      end
      default: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_id_r   <= '0;
      max_id_r    <= MAX_ID_RST;
      reserved_r  <= RESERVED_RST;
      out_valid_r <= 1'b0;
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_r[w] <= '1;
      end
      map_r[0] <= '1 << RESERVED_RST;
    end else begin
      state_r   <= state_nxt;
      last_id_r <= last_id_nxt;
      map_r     <= map_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAX_ID:   max_id_r   <= cfg_data;
          CFG_RESERVED: reserved_r <= cfg_data[4:0];
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser;
      id_r   <= in_tdata;
    end
    hint_r    <= hint_nxt;
    scan_r    <= scan_nxt;
    gid_r     <= gid_nxt;
    res_id_r  <= res_id_nxt;
    res_use_r <= res_use_nxt;
    if (load_out) begin
      out_id_r  <= res_id_r;
      out_use_r <= res_use_r;
    end
  end

endmodule
